/* rtl/mic_pkg.sv */
// ----------------------------------------------------------------------------
// Index converter package
// Shared constants, register codes and item structures of the column-major
// subscript and linear index converter.
// ----------------------------------------------------------------------------
`default_nettype none

package mic_pkg;

  localparam int FIELD_DIMS = 4;
  localparam int EXT_W      = 16;
  localparam int DIMS_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int RESULT_W   = 32;
  localparam int LINEAR_W   = 32;

  localparam int DEF_MAX_DIMS    = 4;
  localparam int DEF_INDEX_WIDTH = 32;

  localparam logic [CFG_IDX_W-1:0] REG_DIMS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_3 = 3'd4;

  localparam logic ACTION_FOLD  = 1'b0;
  localparam logic ACTION_SPLIT = 1'b1;

  typedef logic [EXT_W-1:0] ext_t;

  typedef struct packed {
    logic valid;
    logic sub_err;
    logic sum_big;
    logic stride_big;
    logic ext_zero;
  } fold_flags_t;

  typedef struct packed {
    logic                    action;
    ext_t [FIELD_DIMS-1:0]   sub;
  } fold_side_t;

  typedef struct packed {
    logic                    valid;
    logic                    split_ok;
    logic                    err;
    logic [RESULT_W-1:0]     result;
    ext_t [FIELD_DIMS-1:0]   coord;
  } div_side_t;

endpackage

`default_nettype wire

/* rtl/mic_fold_cell.sv */
// ----------------------------------------------------------------------------
// Fold cell
// Handles one dimension: adds the subscript times the running stride to the
// sum, scales the stride by the extent and tracks range and overflow flags.
// ----------------------------------------------------------------------------
`default_nettype none

module mic_fold_cell import mic_pkg::*; #(
  parameter int INDEX_WIDTH = DEF_INDEX_WIDTH,
  parameter int DIM         = 0
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   active_i,
  input  wire ext_t                   extent_i,
  input  wire fold_flags_t            flags_i,
  input  wire fold_side_t             side_i,
  input  wire logic [INDEX_WIDTH-1:0] stride_i,
  input  wire logic [INDEX_WIDTH-1:0] sum_i,
  input  wire logic [INDEX_WIDTH-1:0] idx_i,
  output fold_flags_t                 flags_o,
  output fold_side_t                  side_o,
  output logic [INDEX_WIDTH-1:0]      stride_o,
  output logic [INDEX_WIDTH-1:0]      sum_o,
  output logic [INDEX_WIDTH-1:0]      idx_o
);

  localparam int W = INDEX_WIDTH;
  localparam logic [1:0] SEL = 2'(DIM);

  ext_t                sub;
  logic [W+EXT_W-1:0]  term_w;
  logic [W+EXT_W-1:0]  stride_w;
  logic [W:0]          sum_w;
  logic                term_big;
  fold_flags_t         flags_d, flags_q;
  fold_side_t          side_q;
  logic [W-1:0]        stride_d, stride_q, sum_q, idx_q;

  always_comb begin
    sub      = active_i ? side_i.sub[SEL] : '0;
    term_w   = {{W{1'b0}}, sub} * {{EXT_W{1'b0}}, stride_i};
    stride_w = {{EXT_W{1'b0}}, stride_i} * {{W{1'b0}}, extent_i};
    sum_w    = {1'b0, sum_i} + {1'b0, term_w[W-1:0]};
    term_big = (|term_w[W+EXT_W-1:W]) || (flags_i.stride_big && (sub != '0));

    flags_d.valid      = flags_i.valid;
    flags_d.sub_err    = flags_i.sub_err || (active_i && (side_i.sub[SEL] >= extent_i));
    flags_d.sum_big    = flags_i.sum_big || term_big || sum_w[W];
    flags_d.stride_big = flags_i.stride_big || (active_i && (|stride_w[W+EXT_W-1:W]));
    flags_d.ext_zero   = flags_i.ext_zero || (active_i && (extent_i == '0));
    stride_d           = active_i ? stride_w[W-1:0] : stride_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else begin
      flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    side_q   <= side_i;
    stride_q <= stride_d;
    sum_q    <= sum_w[W-1:0];
    idx_q    <= idx_i;
  end

  assign flags_o  = flags_q;
  assign side_o   = side_q;
  assign stride_o = stride_q;
  assign sum_o    = sum_q;
  assign idx_o    = idx_q;

endmodule

`default_nettype wire

/* rtl/mic_div_cell.sv */
// ----------------------------------------------------------------------------
// Division cell
// One restoring division step when enabled: brings the next dividend bit into the
// remainder and shifts one quotient bit in.
// ----------------------------------------------------------------------------
`default_nettype none

module mic_div_cell import mic_pkg::*; #(
  parameter int INDEX_WIDTH = DEF_INDEX_WIDTH
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   en_i,
  input  wire ext_t                   divisor_i,
  input  wire div_side_t              side_i,
  input  wire ext_t                   rem_i,
  input  wire logic [INDEX_WIDTH-1:0] quot_i,
  output div_side_t                   side_o,
  output ext_t                        rem_o,
  output logic [INDEX_WIDTH-1:0]      quot_o
);

  localparam int W = INDEX_WIDTH;

  logic [EXT_W:0] shifted;
  logic [EXT_W:0] diff;
  logic           ge;
  ext_t           rem_d, rem_q;
  logic [W-1:0]   quot_d, quot_q;
  div_side_t      side_q;

  always_comb begin
    shifted = {rem_i, quot_i[W-1]};
    diff    = shifted - {1'b0, divisor_i};
    ge      = shifted >= {1'b0, divisor_i};
    if (en_i) begin
      rem_d  = ge ? diff[EXT_W-1:0] : shifted[EXT_W-1:0];
      quot_d = {quot_i[W-2:0], ge};
    end else begin
      rem_d  = rem_i;
      quot_d = quot_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else begin
      side_q <= side_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
  end

  assign side_o = side_q;
  assign rem_o  = rem_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

/* rtl/multidim_index_converter_core.sv */
// ----------------------------------------------------------------------------
// Multidimensional index converter
// Column-major conversion between subscripts and a linear index, built as a
// chain of fold cells followed by a chain of one-bit division cells.
// ----------------------------------------------------------------------------
// An item passes in turn through the fold cells, the check register, the
// division cells and the output register.
// One item is accepted in every cycle; each cell hands its item on every cycle
// and the result strobe cannot be held off, so busy stays low.
// Reset clears the valid bits of all cells and loads one dimension of
// extent one into each register; no clearing pass is needed.
`default_nettype none

module multidim_index_converter_core import mic_pkg::*; #(
  parameter int MAX_DIMS    = DEF_MAX_DIMS,
  parameter int INDEX_WIDTH = DEF_INDEX_WIDTH
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  output logic                      busy_o,
  input  wire logic                 action_i,
  input  wire logic [EXT_W-1:0]     subscript_0_i,
  input  wire logic [EXT_W-1:0]     subscript_1_i,
  input  wire logic [EXT_W-1:0]     subscript_2_i,
  input  wire logic [EXT_W-1:0]     subscript_3_i,
  input  wire logic [LINEAR_W-1:0]  linear_index_i,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [EXT_W-1:0]     cfg_data_i,
  output logic                      res_valid_o,
  output logic [RESULT_W-1:0]       index_result_o,
  output logic [EXT_W-1:0]          coord_0_o,
  output logic [EXT_W-1:0]          coord_1_o,
  output logic [EXT_W-1:0]          coord_2_o,
  output logic [EXT_W-1:0]          coord_3_o,
  output logic                      range_error_o
);

  localparam int W     = INDEX_WIDTH;
  localparam int NCELL = (MAX_DIMS < FIELD_DIMS) ? MAX_DIMS : FIELD_DIMS;
  localparam int NDIV  = NCELL - 1;
  localparam int NSTEP = NDIV * W;
  localparam logic [DIMS_W-1:0] NCELL_D   = DIMS_W'(NCELL);
  localparam logic [DIMS_W-1:0] LASTDIV_D = DIMS_W'(NDIV - 1);
  localparam logic [1:0]        LASTSEL   = 2'(NDIV - 1);

  logic [DIMS_W-1:0] dims_q;
  ext_t              ext_q [FIELD_DIMS];
  logic [DIMS_W-1:0] used;
  logic [DIMS_W-1:0] used_m1;
  logic              accept;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q <= DIMS_W'(1);
      for (int i = 0; i < FIELD_DIMS; i++) begin
        ext_q[i] <= EXT_W'(1);
      end
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_DIMS:     dims_q   <= cfg_data_i[DIMS_W-1:0];
        REG_EXTENT_0: ext_q[0] <= cfg_data_i;
        REG_EXTENT_1: ext_q[1] <= cfg_data_i;
        REG_EXTENT_2: ext_q[2] <= cfg_data_i;
        REG_EXTENT_3: ext_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (dims_q == '0) begin
      used = DIMS_W'(1);
    end else if (dims_q > NCELL_D) begin
      used = NCELL_D;
    end else begin
      used = dims_q;
    end
    used_m1 = used - DIMS_W'(1);
  end

  fold_flags_t   f_flags  [NCELL+1];
  fold_side_t    f_side   [NCELL+1];
  logic [W-1:0]  f_stride [NCELL+1];
  logic [W-1:0]  f_sum    [NCELL+1];
  logic [W-1:0]  f_idx    [NCELL+1];
  logic [W+LINEAR_W-1:0] idx_ext;

  always_comb begin
    idx_ext            = {{W{1'b0}}, linear_index_i};
    f_flags[0]         = '0;
    f_flags[0].valid   = accept;
    f_side[0].action   = action_i;
    f_side[0].sub[0]   = subscript_0_i;
    f_side[0].sub[1]   = subscript_1_i;
    f_side[0].sub[2]   = subscript_2_i;
    f_side[0].sub[3]   = subscript_3_i;
    f_stride[0]        = W'(1);
    f_sum[0]           = '0;
    f_idx[0]           = idx_ext[W-1:0];
  end

  for (genvar k = 0; k < NCELL; k++) begin : g_fold
    mic_fold_cell #(
      .INDEX_WIDTH (W),
      .DIM         (k)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .active_i (DIMS_W'(k) < used),
      .extent_i (ext_q[k]),
      .flags_i  (f_flags[k]),
      .side_i   (f_side[k]),
      .stride_i (f_stride[k]),
      .sum_i    (f_sum[k]),
      .idx_i    (f_idx[k]),
      .flags_o  (f_flags[k+1]),
      .side_o   (f_side[k+1]),
      .stride_o (f_stride[k+1]),
      .sum_o    (f_sum[k+1]),
      .idx_o    (f_idx[k+1])
    );
  end

  div_side_t             chk_side_d, chk_side_q;
  logic [W-1:0]          chk_quot_q;
  logic [W+RESULT_W-1:0] sum_ext;
  logic                  split_err;
  logic                  fold_err;

  always_comb begin
    sum_ext   = {{RESULT_W{1'b0}}, f_sum[NCELL]};
    split_err = f_flags[NCELL].ext_zero ||
                (!f_flags[NCELL].stride_big && (f_idx[NCELL] >= f_stride[NCELL]));
    fold_err  = f_flags[NCELL].sub_err || f_flags[NCELL].sum_big;
    chk_side_d       = '0;
    chk_side_d.valid = f_flags[NCELL].valid;
    if (f_side[NCELL].action == ACTION_SPLIT) begin
      chk_side_d.err      = split_err;
      chk_side_d.split_ok = !split_err;
    end else begin
      chk_side_d.err    = fold_err;
      chk_side_d.result = sum_ext[RESULT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chk_side_q <= '0;
    end else begin
      chk_side_q <= chk_side_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_quot_q <= f_idx[NCELL];
  end

  div_side_t    d_side [NSTEP+1];
  ext_t         d_rem  [NSTEP+1];
  logic [W-1:0] d_quot [NSTEP+1];

  assign d_side[0] = chk_side_q;
  assign d_rem[0]  = '0;
  assign d_quot[0] = chk_quot_q;

  for (genvar k = 0; k < NDIV; k++) begin : g_div
    for (genvar j = 0; j < W; j++) begin : g_step
      localparam int N = k * W + j;
      div_side_t side_in;
      ext_t      rem_in;
      logic      en;

      always_comb begin
        side_in = d_side[N];
        rem_in  = d_rem[N];
        if (j == 0) begin
          rem_in = '0;
          if ((k > 0) && d_side[N].split_ok && (DIMS_W'(k - 1) < used_m1)) begin
            side_in.coord[2'(k - 1)] = d_rem[N];
          end
        end
        en = d_side[N].split_ok && (DIMS_W'(k) < used_m1);
      end

      mic_div_cell #(
        .INDEX_WIDTH (W)
      ) u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .en_i      (en),
        .divisor_i (ext_q[k]),
        .side_i    (side_in),
        .rem_i     (rem_in),
        .quot_i    (d_quot[N]),
        .side_o    (d_side[N+1]),
        .rem_o     (d_rem[N+1]),
        .quot_o    (d_quot[N+1])
      );
    end
  end

  div_side_t out_d;
  logic                  res_valid_q;
  logic [RESULT_W-1:0]   index_result_q;
  ext_t [FIELD_DIMS-1:0] coord_q;
  logic                  range_error_q;

  always_comb begin
    out_d = d_side[NSTEP];
    if (out_d.split_ok && (LASTDIV_D < used_m1)) begin
      out_d.coord[LASTSEL] = d_rem[NSTEP];
    end
    if (out_d.split_ok) begin
      out_d.coord[used_m1[1:0]] = d_quot[NSTEP][EXT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= out_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    index_result_q <= out_d.result;
    coord_q        <= out_d.coord;
    range_error_q  <= out_d.err;
  end

  assign res_valid_o    = res_valid_q;
  assign index_result_o = index_result_q;
  assign coord_0_o      = coord_q[0];
  assign coord_1_o      = coord_q[1];
  assign coord_2_o      = coord_q[2];
  assign coord_3_o      = coord_q[3];
  assign range_error_o  = range_error_q;

`ifndef ASSERT_OFF
  ast_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> f_flags[1].valid)
    else $error("Accepted item did not enter the first fold cell.");

  ast_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chk_side_q.valid |-> ##(NSTEP + 1) res_valid_q)
    else $error("Item lost in the division chain.");

  ast_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && (index_result_q != '0)) |->
      ((coord_q[0] == '0) && (coord_q[1] == '0) && (coord_q[2] == '0) &&
       (coord_q[3] == '0)))
    else $error("Index and coordinates both carry data.");
`endif

endmodule

`default_nettype wire

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// Index converter testbench
// Drives subscript-to-index and index-to-subscript items through the converter
// under several dimension and extent settings, predicts every result from its
// own column-major arithmetic and compares each strobed result field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import mic_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = REG_EXTENT_3 + 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = '1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 130;

  typedef struct packed {
    logic [RESULT_W-1:0] index_result;
    ext_t                coord_0;
    ext_t                coord_1;
    ext_t                coord_2;
    ext_t                coord_3;
    logic                range_error;
  } conversion_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic action_i = ACTION_FOLD;
  ext_t subscript_0_i = '0;
  ext_t subscript_1_i = '0;
  ext_t subscript_2_i = '0;
  ext_t subscript_3_i = '0;
  logic [LINEAR_W-1:0] linear_index_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  ext_t cfg_data_i = '0;
  logic res_valid_o;
  logic [RESULT_W-1:0] index_result_o;
  ext_t coord_0_o, coord_1_o, coord_2_o, coord_3_o;
  logic range_error_o;

  conversion_t pending_conversions[$];
  logic [DIMS_W-1:0] dims_setting;
  ext_t extent_setting[FIELD_DIMS];
  int error_count = 0;
  int cycle_count = 0;
  int burst_left = 0;

  multidim_index_converter_core dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .action_i,
    .subscript_0_i, .subscript_1_i, .subscript_2_i, .subscript_3_i,
    .linear_index_i, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .res_valid_o, .index_result_o, .coord_0_o, .coord_1_o, .coord_2_o,
    .coord_3_o, .range_error_o
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic int active_dims();
    int d;
    d = int'(dims_setting);
    if (d < 1) d = 1;
    if (d > FIELD_DIMS) d = FIELD_DIMS;
    return d;
  endfunction

  function automatic logic [63:0] extent_product();
    logic [63:0] prod;
    prod = 64'd1;
    for (int k = 0; k < active_dims(); k++) prod = prod * extent_setting[k];
    return prod;
  endfunction

  function automatic conversion_t convert(logic act, ext_t s0, ext_t s1, ext_t s2,
                                          ext_t s3, logic [LINEAR_W-1:0] lin);
    conversion_t r;
    ext_t subs[FIELD_DIMS];
    ext_t coords[FIELD_DIMS];
    logic [79:0] sum;
    logic [63:0] stride;
    logic [63:0] rest;
    logic [63:0] prod;
    int d;
    d = active_dims();
    subs = '{s0, s1, s2, s3};
    coords = '{default: '0};
    r = '0;
    if (act == ACTION_FOLD) begin
      sum = '0;
      stride = 64'd1;
      for (int k = 0; k < d; k++) begin
        if (subs[k] >= extent_setting[k]) r.range_error = 1'b1;
        sum = sum + 80'(subs[k]) * 80'(stride);
        stride = stride * extent_setting[k];
      end
      if (sum[79:RESULT_W] != '0) r.range_error = 1'b1;
      r.index_result = sum[RESULT_W-1:0];
    end else begin
      prod = extent_product();
      rest = 64'(lin);
      if (rest >= prod) begin
        r.range_error = 1'b1;
      end else begin
        for (int k = 0; k < d - 1; k++) begin
          coords[k] = ext_t'(rest % extent_setting[k]);
          rest = rest / extent_setting[k];
        end
        coords[d-1] = ext_t'(rest);
      end
    end
    r.coord_0 = coords[0];
    r.coord_1 = coords[1];
    r.coord_2 = coords[2];
    r.coord_3 = coords[3];
    return r;
  endfunction

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, ext_t data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == REG_DIMS) dims_setting = data[DIMS_W-1:0];
    else if (idx >= REG_EXTENT_0 && idx <= REG_EXTENT_3)
      extent_setting[idx - REG_EXTENT_0] = data;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_conversions.size() != 0) @(posedge clk_i);
  endtask

  task automatic configure(logic [DIMS_W-1:0] dims, ext_t e0, ext_t e1, ext_t e2, ext_t e3);
    wait_idle();
    write_register(REG_DIMS, ext_t'(dims));
    write_register(REG_EXTENT_0, e0);
    write_register(REG_EXTENT_1, e1);
    write_register(REG_EXTENT_2, e2);
    write_register(REG_EXTENT_3, e3);
  endtask

  task automatic send_item(logic act, ext_t s0, ext_t s1, ext_t s2, ext_t s3,
                           logic [LINEAR_W-1:0] lin);
    @(negedge clk_i);
    start_i = 1'b1;
    action_i = act;
    subscript_0_i = s0;
    subscript_1_i = s1;
    subscript_2_i = s2;
    subscript_3_i = s3;
    linear_index_i = lin;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pending_conversions.insert(pending_conversions.size(),
                               convert(act, s0, s1, s2, s3, lin));
  endtask

  task automatic pause_sender(int n);
    @(negedge clk_i);
    start_i = 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  task automatic paced_gap();
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 6));
      burst_left = $urandom_range(1, 25);
    end else begin
      burst_left--;
    end
  endtask

  task automatic test_reset_defaults();
    dims_setting = 3'd1;
    extent_setting = '{default: ext_t'(1)};
    send_item(ACTION_FOLD, '0, '1, '1, '1, '0);
    send_item(ACTION_FOLD, 16'd1, '0, '0, '0, '0);
    send_item(ACTION_SPLIT, '0, '0, '0, '0, '0);
    send_item(ACTION_SPLIT, '0, '0, '0, '0, 32'd1);
    pause_sender(1);
  endtask

  task automatic test_directed();
    configure(3'd4, 16'd3, 16'd5, 16'd7, 16'd11);
    send_item(ACTION_FOLD, 16'd2, 16'd4, 16'd6, 16'd10, '0);
    send_item(ACTION_FOLD, 16'd3, 16'd0, 16'd0, 16'd0, '0);
    send_item(ACTION_SPLIT, '1, '1, '1, '1, 32'd1154);
    send_item(ACTION_SPLIT, '0, '0, '0, '0, 32'd1155);
    send_item(ACTION_SPLIT, '0, '0, '0, '0, '1);
    pause_sender(1);
    configure(3'd4, '1, '1, '1, '1);
    send_item(ACTION_FOLD, '1, '1, '1, '1, '0);
    send_item(ACTION_FOLD, 16'hFFFE, 16'hFFFE, 16'd0, 16'd0, '0);
    send_item(ACTION_FOLD, 16'd0, 16'd1, 16'd1, 16'd0, '0);
    send_item(ACTION_SPLIT, '0, '0, '0, '0, '1);
    send_item(ACTION_SPLIT, '0, '0, '0, '0, 32'h8000_0001);
    pause_sender(1);
    configure(3'd0, 16'd9, 16'd0, 16'd4, 16'd4);
    send_item(ACTION_FOLD, 16'd8, '1, '1, '1, '0);
    send_item(ACTION_SPLIT, '0, '0, '0, '0, 32'd8);
    pause_sender(1);
    configure(3'd7, 16'd4, 16'd0, 16'd4, 16'd4);
    send_item(ACTION_FOLD, 16'd1, 16'd0, 16'd0, 16'd0, '0);
    send_item(ACTION_SPLIT, '0, '0, '0, '0, '0);
    pause_sender(1);
    configure(3'd2, 16'd6, 16'd6, 16'd0, 16'd0);
    wait_idle();
    write_register(REG_UNUSED_LO, 16'd1);
    write_register(REG_UNUSED_HI, 16'hAAAA);
    send_item(ACTION_FOLD, 16'd5, 16'd5, '1, '1, '0);
    send_item(ACTION_SPLIT, '0, '0, '0, '0, 32'd35);
    send_item(ACTION_SPLIT, '0, '0, '0, '0, 32'd36);
    pause_sender(1);
  endtask

  task automatic random_config();
    ext_t e[FIELD_DIMS];
    for (int k = 0; k < FIELD_DIMS; k++) begin
      case ($urandom_range(0, 9))
        0: e[k] = '1;
        1: e[k] = ext_t'($urandom);
        2: e[k] = '0;
        default: e[k] = ext_t'($urandom_range(1, 40));
      endcase
    end
    configure(($urandom_range(0, 7) == 0) ? DIMS_W'($urandom) : DIMS_W'($urandom_range(1, 4)),
              e[0], e[1], e[2], e[3]);
    if ($urandom_range(0, 3) == 0)
      write_register(DIMS_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)), ext_t'($urandom));
  endtask

  task automatic test_random(int items);
    ext_t s[FIELD_DIMS];
    logic [LINEAR_W-1:0] lin;
    logic [63:0] prod;
    for (int n = 0; n < items; n++) begin
      if (n % 50 == 0) begin
        pause_sender(1);
        random_config();
        burst_left = 0;
      end
      for (int k = 0; k < FIELD_DIMS; k++) begin
        if ($urandom_range(0, 7) == 0 || extent_setting[k] == '0) s[k] = ext_t'($urandom);
        else s[k] = ext_t'($urandom_range(0, extent_setting[k] - 1));
      end
      prod = extent_product();
      lin = $urandom;
      if (prod != 0 && prod <= 64'hFFFF_FFFF && $urandom_range(0, 5) != 0)
        lin = LINEAR_W'(64'(lin) % prod);
      send_item(logic'($urandom_range(0, 1)), s[0], s[1], s[2], s[3], lin);
      if ((n / 100) % 3 != 2) paced_gap();
    end
    pause_sender(1);
  endtask

  always @(posedge clk_i) begin
    conversion_t want;
    if (rst_ni && res_valid_o) begin
      if (pending_conversions.size() == 0) begin
        $error("unexpected result: index_result %h", index_result_o);
        error_count++;
      end else begin
        want = pending_conversions.pop_front();
        if (index_result_o !== want.index_result) begin
          $error("index_result: expected %h, got %h", want.index_result, index_result_o);
          error_count++;
        end
        if (coord_0_o !== want.coord_0) begin
          $error("coord_0: expected %h, got %h", want.coord_0, coord_0_o);
          error_count++;
        end
        if (coord_1_o !== want.coord_1) begin
          $error("coord_1: expected %h, got %h", want.coord_1, coord_1_o);
          error_count++;
        end
        if (coord_2_o !== want.coord_2) begin
          $error("coord_2: expected %h, got %h", want.coord_2, coord_2_o);
          error_count++;
        end
        if (coord_3_o !== want.coord_3) begin
          $error("coord_3: expected %h, got %h", want.coord_3, coord_3_o);
          error_count++;
        end
        if (range_error_o !== want.range_error) begin
          $error("range_error: expected %b, got %b", want.range_error, range_error_o);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_defaults();
    test_directed();
    test_random(700);
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0 && pending_conversions.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
